// ===== rtl/core/tlf_pkg.sv =====
// Shared types and constants of the track linearity filter.
package tlf_pkg;

    // Limb width of the shared multiplier and derived accumulator widths
    localparam int LIMB_W = 17;
    localparam int MAG_W  = 2 * LIMB_W;
    localparam int WIDE_W = 4 * LIMB_W;
    localparam int ACC_W  = 5 * LIMB_W;

    // Fixed field widths
    localparam int MOTION_W   = 13;
    localparam int HEAD_W     = 14;
    localparam int TOTAL_W    = 16;
    localparam int RUN_LEN_W  = 8;
    localparam int COS_W      = 17;
    localparam int COS_FRAC_W = 16;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic REG_RUN_LENGTH   = 1'b0;
    localparam logic REG_COS_SQ_LIMIT = 1'b1;

    localparam logic [RUN_LEN_W-1:0] RUN_LENGTH_RST = 8'd3;
    localparam logic [COS_W-1:0]     COS_SQ_RST     = 17'd38457;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIR,
        S_DOT,
        S_NU,
        S_NV,
        S_D2,
        S_P,
        S_R,
        S_FIN
    } seq_state_t;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_TRUE,
        DEC_FALSE
    } run_dec_t;

    typedef struct packed {
        logic       en;
        logic       clear;
        logic       neg;
        logic [1:0] shift;
    } mac_ctrl_t;

endpackage

// ===== rtl/core/tlf_if.sv =====
// Handshake interfaces for detection input and verdict output channels.
interface tlf_det_if #(
    parameter int COORD_BITS = 12
);
    import tlf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [COORD_BITS-1:0]      center_x;
    logic [COORD_BITS-1:0]      center_y;
    logic signed [MOTION_W-1:0] motion_x;
    logic signed [MOTION_W-1:0] motion_y;

    modport source (
        output valid, center_x, center_y, motion_x, motion_y,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, motion_x, motion_y,
        output ready
    );
endinterface

interface tlf_res_if;
    import tlf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic                     checkpoint;
    logic                     point_good;
    logic                     still_linear;
    logic                     good_run_seen;
    logic                     bad_run_seen;
    logic                     direction_majority;
    logic [TOTAL_W-1:0]       good_total;
    logic signed [HEAD_W-1:0] heading_x;
    logic signed [HEAD_W-1:0] heading_y;

    modport source (
        output valid, accepted, checkpoint, point_good, still_linear, good_run_seen,
               bad_run_seen, direction_majority, good_total, heading_x, heading_y,
        input  ready
    );

    modport sink (
        input  valid, accepted, checkpoint, point_good, still_linear, good_run_seen,
               bad_run_seen, direction_majority, good_total, heading_x, heading_y,
        output ready
    );
endinterface

// ===== rtl/core/tlf_mac.sv =====
// Shared limb multiplier with shifted signed accumulate.
module tlf_mac (
    input  logic                             clk,
    input  tlf_pkg::mac_ctrl_t               ctrl,
    input  logic [tlf_pkg::LIMB_W-1:0]       op_a,
    input  logic [tlf_pkg::LIMB_W-1:0]       op_b,
    output logic signed [tlf_pkg::ACC_W-1:0] acc,
    output logic signed [tlf_pkg::ACC_W-1:0] sum
);
    import tlf_pkg::*;

    logic [MAG_W-1:0]        prod;
    logic [ACC_W-1:0]        term_mag;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_reg;

    assign prod = op_a * op_b;

    // Place the partial product at its limb position
    always_comb
    begin
        unique case (ctrl.shift)
            2'd0: term_mag = ACC_W'(prod);
            2'd1: term_mag = ACC_W'(prod) << LIMB_W;
            2'd2: term_mag = ACC_W'(prod) << (2 * LIMB_W);
            2'd3: term_mag = ACC_W'(prod) << (3 * LIMB_W);
        endcase
    end

    assign term = ctrl.neg ? -$signed(term_mag) : $signed(term_mag);
    assign base = ctrl.clear ? '0 : acc_reg;
    assign sum  = base + term;
    assign acc  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= sum;
        end
    end

endmodule

// ===== rtl/core/track_linearity_filter.sv =====
// Top level of the track linearity filter: sequencer, track state and ports.
//
// Usage: one detection (center, motion vector) enters per det transaction and
// exactly one verdict leaves per res transaction, in order. The block keeps the
// first and last main points of the track and, on every third track position,
// tests the step from the last main point against the track line with an exact
// Q16 squared-cosine compare. Run decisions, the linear flag and the direction
// majority are reported with every verdict.
// Datapath: all products go through one 17x17 multiplier with an 85-bit
// accumulator. A plain item runs the direction check, then the final step;
// a checkpoint with two main points runs direction, dot, two norms, squared
// dot, norm product and threshold product, then the final step.
// det.ready is high only while the sequencer idles, so a new item is taken
// only once the last one has left the final step.
// Stall: a finished verdict waits in the output register; a new item is taken
// meanwhile, and its verdict holds in the final step until res.ready frees it.
// Reset: asynchronous, active low; track state, counters and the run decisions
// return to their start values and run_length = 3, cos_sq_limit = 38457.
// Configuration: APB at byte addresses 0 (run_length) and 4 (cos_sq_limit);
// they are to be written only while idle, which the block does not enforce.
module track_linearity_filter #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tlf_det_if.sink                             det,
    tlf_res_if.source                           res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [tlf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tlf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import tlf_pkg::*;

    localparam int SW    = COORD_BITS + 1;
    localparam int CMP_W = (COUNT_BITS > RUN_LEN_W) ? COUNT_BITS : RUN_LEN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_TWO = COUNT_BITS'(2);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : COUNT_BITS'(v + 1'b1);
    endfunction

    function automatic logic [LIMB_W-1:0] mag_s(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = v[SW-1] ? (~v + 1'b1) : v;
        return LIMB_W'(m);
    endfunction

    function automatic logic [LIMB_W-1:0] mag_m(input logic signed [MOTION_W-1:0] v);
        logic [MOTION_W-1:0] m;
        m = v[MOTION_W-1] ? (~v + 1'b1) : v;
        return LIMB_W'(m);
    endfunction

    function automatic logic [LIMB_W-1:0] limb_of(input logic [MAG_W-1:0] v, input logic sel);
        return sel ? v[MAG_W-1 -: LIMB_W] : v[LIMB_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [RUN_LEN_W-1:0] run_len_reg;
    logic [COS_W-1:0]     cos_lim_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= RUN_LENGTH_RST;
            cos_lim_reg <= COS_SQ_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[CFG_ADDR_W-1])
                REG_RUN_LENGTH:   run_len_reg <= pwdata[RUN_LEN_W-1:0];
                REG_COS_SQ_LIMIT: cos_lim_reg <= pwdata[COS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[CFG_ADDR_W-1])
            REG_RUN_LENGTH:   prdata = CFG_DATA_W'(run_len_reg);
            REG_COS_SQ_LIMIT: prdata = CFG_DATA_W'(cos_lim_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Track state
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] acc_cnt_reg,    acc_cnt_next;
    logic [1:0]            mod3_reg,       mod3_next;
    logic [COUNT_BITS-1:0] good_cnt_reg,   good_cnt_next;
    logic [COUNT_BITS-1:0] bad_streak_reg, bad_streak_next;
    logic [COORD_BITS-1:0] first_x_reg,    first_x_next;
    logic [COORD_BITS-1:0] first_y_reg,    first_y_next;
    logic [COORD_BITS-1:0] last_x_reg,     last_x_next;
    logic [COORD_BITS-1:0] last_y_reg,     last_y_next;
    logic [1:0]            main_cnt_reg,   main_cnt_next;
    logic signed [SW-1:0]  step_x_reg,     step_x_next;
    logic signed [SW-1:0]  step_y_reg,     step_y_next;
    logic [1:0]            step_cnt_reg,   step_cnt_next;
    logic                  linear_reg,     linear_next;
    logic [COUNT_BITS-1:0] run_streak_reg, run_streak_next;
    logic                  run_last_reg,   run_last_next;
    run_dec_t              good_dec_reg,   good_dec_next;
    run_dec_t              bad_dec_reg,    bad_dec_next;
    logic [COUNT_BITS-1:0] agree_cnt_reg,  agree_cnt_next;
    logic [COUNT_BITS-1:0] check_cnt_reg,  check_cnt_next;

    // Item latched at acceptance, with track line u and step v
    logic [COORD_BITS-1:0]      cx_reg, cy_reg;
    logic signed [MOTION_W-1:0] mx_reg, my_reg;
    logic signed [SW-1:0]       ux_reg, uy_reg, vx_reg, vy_reg;

    // Intermediate results of the shared unit
    logic                dir_pos_reg;
    logic                dot_neg_reg;
    logic [MAG_W-1:0]    dot_mag_reg;
    logic [MAG_W-1:0]    nu_reg;
    logic [MAG_W-1:0]    nv_reg;
    logic [WIDE_W-1:0]   d2_reg;
    logic [WIDE_W-1:0]   p_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;
    logic [1:0] step_reg,  step_next;
    logic       last_step;
    logic       is_long;
    logic       in_fire;
    logic       fin_fire;
    logic       res_valid_reg;
    logic       is_first;
    logic       chk_slot;
    logic       full_test;

    assign det.ready = (state_reg == S_IDLE);
    assign in_fire   = det.valid && det.ready;
    assign fin_fire  = (state_reg == S_FIN) && (!res_valid_reg || res.ready);
    assign is_long   = (state_reg == S_D2) || (state_reg == S_P) || (state_reg == S_R);
    assign last_step = (step_reg == (is_long ? 2'd3 : 2'd1));
    assign is_first  = (acc_cnt_reg == '0);
    assign chk_slot  = !is_first && (mod3_reg == 2'd2);
    assign full_test = chk_slot && (main_cnt_reg == 2'd2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            S_IDLE: if (det.valid) state_next = S_DIR;
            S_DIR:  if (last_step) state_next = full_test ? S_DOT : S_FIN;
            S_DOT:  if (last_step) state_next = S_NU;
            S_NU:   if (last_step) state_next = S_NV;
            S_NV:   if (last_step) state_next = S_D2;
            S_D2:   if (last_step) state_next = S_P;
            S_P:    if (last_step) state_next = S_R;
            S_R:    if (last_step) state_next = S_FIN;
            S_FIN:  if (fin_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if ((state_reg != S_IDLE) && (state_reg != S_FIN) && !last_step)
        begin
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Operand selection and capture strobes for the shared unit
    mac_ctrl_t               mac_ctrl;
    logic [LIMB_W-1:0]       op_a, op_b;
    logic signed [ACC_W-1:0] mac_acc, mac_sum;
    logic cap_dir, cap_dot, cap_nu, cap_nv, cap_d2, cap_p;

    always_comb
    begin
        mac_ctrl       = '0;
        mac_ctrl.clear = (step_reg == 2'd0);
        op_a           = '0;
        op_b           = '0;
        cap_dir        = 1'b0;
        cap_dot        = 1'b0;
        cap_nu         = 1'b0;
        cap_nv         = 1'b0;
        cap_d2         = 1'b0;
        cap_p          = 1'b0;
        unique case (state_reg)
            S_DIR:
            begin
                mac_ctrl.en = 1'b1;
                cap_dir     = last_step;
                if (step_reg[0])
                begin
                    op_a         = mag_m(my_reg);
                    op_b         = mag_s(step_y_reg);
                    mac_ctrl.neg = my_reg[MOTION_W-1] ^ step_y_reg[SW-1];
                end
                else
                begin
                    op_a         = mag_m(mx_reg);
                    op_b         = mag_s(step_x_reg);
                    mac_ctrl.neg = mx_reg[MOTION_W-1] ^ step_x_reg[SW-1];
                end
            end
            S_DOT:
            begin
                mac_ctrl.en = 1'b1;
                cap_dot     = last_step;
                if (step_reg[0])
                begin
                    op_a         = mag_s(uy_reg);
                    op_b         = mag_s(vy_reg);
                    mac_ctrl.neg = uy_reg[SW-1] ^ vy_reg[SW-1];
                end
                else
                begin
                    op_a         = mag_s(ux_reg);
                    op_b         = mag_s(vx_reg);
                    mac_ctrl.neg = ux_reg[SW-1] ^ vx_reg[SW-1];
                end
            end
            S_NU:
            begin
                mac_ctrl.en = 1'b1;
                cap_nu      = last_step;
                op_a        = step_reg[0] ? mag_s(uy_reg) : mag_s(ux_reg);
                op_b        = op_a;
            end
            S_NV:
            begin
                mac_ctrl.en = 1'b1;
                cap_nv      = last_step;
                op_a        = step_reg[0] ? mag_s(vy_reg) : mag_s(vx_reg);
                op_b        = op_a;
            end
            S_D2:
            begin
                mac_ctrl.en    = 1'b1;
                cap_d2         = last_step;
                op_a           = limb_of(dot_mag_reg, step_reg[0]);
                op_b           = limb_of(dot_mag_reg, step_reg[1]);
                mac_ctrl.shift = 2'({1'b0, step_reg[0]} + {1'b0, step_reg[1]});
            end
            S_P:
            begin
                mac_ctrl.en    = 1'b1;
                cap_p          = last_step;
                op_a           = limb_of(nu_reg, step_reg[0]);
                op_b           = limb_of(nv_reg, step_reg[1]);
                mac_ctrl.shift = 2'({1'b0, step_reg[0]} + {1'b0, step_reg[1]});
            end
            S_R:
            begin
                mac_ctrl.en    = 1'b1;
                op_a           = p_reg[step_reg * LIMB_W +: LIMB_W];
                op_b           = cos_lim_reg;
                mac_ctrl.shift = step_reg;
            end
            S_IDLE, S_FIN: ;
            default: ;
        endcase
    end

    tlf_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (mac_acc),
        .sum  (mac_sum)
    );

    // Latch the item and capture phase results; payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cx_reg <= det.center_x;
            cy_reg <= det.center_y;
            mx_reg <= det.motion_x;
            my_reg <= det.motion_y;
            ux_reg <= $signed({1'b0, last_x_reg}) - $signed({1'b0, first_x_reg});
            uy_reg <= $signed({1'b0, last_y_reg}) - $signed({1'b0, first_y_reg});
            vx_reg <= $signed({1'b0, det.center_x}) - $signed({1'b0, last_x_reg});
            vy_reg <= $signed({1'b0, det.center_y}) - $signed({1'b0, last_y_reg});
        end
        if (cap_dir)
        begin
            dir_pos_reg <= (mac_sum > 0);
        end
        if (cap_dot)
        begin
            dot_neg_reg <= mac_sum[ACC_W-1];
            dot_mag_reg <= mac_sum[MAG_W-1:0];
        end
        if (cap_nu)
        begin
            nu_reg <= mac_sum[MAG_W-1:0];
        end
        if (cap_nv)
        begin
            nv_reg <= mac_sum[MAG_W-1:0];
        end
        if (cap_d2)
        begin
            d2_reg <= mac_sum[WIDE_W-1:0];
        end
        if (cap_p)
        begin
            p_reg <= mac_sum[WIDE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Verdict and state update
    // ------------------------------------------------------------------
    logic             u_zero, v_zero;
    logic [ACC_W-1:0] lhs_q, rhs_q;
    logic             angle_good;
    logic             item_acc, item_chk, item_good, do_push, do_rec;
    logic             majority_next;

    assign u_zero     = (ux_reg == '0) && (uy_reg == '0);
    assign v_zero     = (vx_reg == '0) && (vy_reg == '0);
    // dot^2 scaled to Q16 against cos_sq * |u|^2 * |v|^2 held in the accumulator
    assign lhs_q      = ACC_W'({d2_reg, {COS_FRAC_W{1'b0}}});
    assign rhs_q      = mac_acc;
    assign angle_good = !dot_neg_reg && (lhs_q >= rhs_q);

    always_comb
    begin
        acc_cnt_next    = acc_cnt_reg;
        mod3_next       = mod3_reg;
        good_cnt_next   = good_cnt_reg;
        bad_streak_next = bad_streak_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        main_cnt_next   = main_cnt_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        step_cnt_next   = step_cnt_reg;
        linear_next     = linear_reg;
        run_streak_next = run_streak_reg;
        run_last_next   = run_last_reg;
        good_dec_next   = good_dec_reg;
        bad_dec_next    = bad_dec_reg;
        agree_cnt_next  = agree_cnt_reg;
        check_cnt_next  = check_cnt_reg;
        item_acc        = 1'b1;
        item_chk        = 1'b0;
        item_good       = 1'b0;
        do_push         = 1'b0;
        do_rec          = 1'b0;

        if (is_first)
        begin
            do_push   = 1'b1;
            item_chk  = 1'b1;
            item_good = 1'b1;
            do_rec    = 1'b1;
        end
        else
        begin
            // Direction vote against the previous checkpoint step
            if (step_cnt_reg == 2'd2)
            begin
                check_cnt_next = sat_inc(check_cnt_reg);
                if (dir_pos_reg)
                begin
                    agree_cnt_next = sat_inc(agree_cnt_reg);
                end
            end
            if (chk_slot)
            begin
                item_chk = 1'b1;
                if (main_cnt_reg == 2'd2)
                begin
                    step_x_next = vx_reg;
                    step_y_next = vy_reg;
                    if (step_cnt_reg != 2'd2)
                    begin
                        step_cnt_next = step_cnt_reg + 2'd1;
                    end
                    // Degenerate line or step: bad, streak untouched
                    priority if (u_zero || v_zero)
                    begin
                        item_good = 1'b0;
                    end
                    else if (!angle_good)
                    begin
                        item_good       = 1'b0;
                        bad_streak_next = sat_inc(bad_streak_reg);
                        if (bad_streak_next == CNT_TWO)
                        begin
                            linear_next = 1'b0;
                        end
                    end
                    else
                    begin
                        item_good       = 1'b1;
                        bad_streak_next = '0;
                        do_push         = 1'b1;
                    end
                end
                else
                begin
                    item_good = 1'b1;
                    do_push   = 1'b1;
                end
                item_acc = item_good;
                do_rec   = 1'b1;
            end
        end

        if (do_push)
        begin
            if (main_cnt_reg == 2'd0)
            begin
                first_x_next = cx_reg;
                first_y_next = cy_reg;
            end
            last_x_next = cx_reg;
            last_y_next = cy_reg;
            if (main_cnt_reg != 2'd2)
            begin
                main_cnt_next = main_cnt_reg + 2'd1;
            end
            good_cnt_next = sat_inc(good_cnt_reg);
        end

        // Track position modulo three follows the count until it saturates
        if (item_acc)
        begin
            acc_cnt_next = sat_inc(acc_cnt_reg);
            if (acc_cnt_reg != CNT_MAX)
            begin
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end

        if (do_rec)
        begin
            if ((run_streak_reg != '0) && (item_good == run_last_reg))
            begin
                run_streak_next = sat_inc(run_streak_reg);
            end
            else
            begin
                run_streak_next = CNT_ONE;
                run_last_next   = item_good;
            end
            if (good_dec_reg == DEC_NONE)
            begin
                if (item_good && (CMP_W'(run_streak_next) >= CMP_W'(run_len_reg)))
                begin
                    good_dec_next = DEC_TRUE;
                end
                else if (!item_good && (run_streak_next == CNT_TWO))
                begin
                    good_dec_next = DEC_FALSE;
                end
            end
            if (bad_dec_reg == DEC_NONE)
            begin
                if (!item_good && (CMP_W'(run_streak_next) >= CMP_W'(run_len_reg)))
                begin
                    bad_dec_next = DEC_TRUE;
                end
                else if (item_good && (run_streak_next == CNT_TWO))
                begin
                    bad_dec_next = DEC_FALSE;
                end
            end
        end

        majority_next = (agree_cnt_next != '0) &&
                        ({agree_cnt_next, 1'b0} >= {1'b0, check_cnt_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg    <= '0;
            mod3_reg       <= '0;
            good_cnt_reg   <= '0;
            bad_streak_reg <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            main_cnt_reg   <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            step_cnt_reg   <= '0;
            linear_reg     <= 1'b1;
            run_streak_reg <= '0;
            run_last_reg   <= 1'b0;
            good_dec_reg   <= DEC_NONE;
            bad_dec_reg    <= DEC_NONE;
            agree_cnt_reg  <= '0;
            check_cnt_reg  <= '0;
        end
        else if (fin_fire)
        begin
            acc_cnt_reg    <= acc_cnt_next;
            mod3_reg       <= mod3_next;
            good_cnt_reg   <= good_cnt_next;
            bad_streak_reg <= bad_streak_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            main_cnt_reg   <= main_cnt_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            step_cnt_reg   <= step_cnt_next;
            linear_reg     <= linear_next;
            run_streak_reg <= run_streak_next;
            run_last_reg   <= run_last_next;
            good_dec_reg   <= good_dec_next;
            bad_dec_reg    <= bad_dec_next;
            agree_cnt_reg  <= agree_cnt_next;
            check_cnt_reg  <= check_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            res.accepted           <= item_acc;
            res.checkpoint         <= item_chk;
            res.point_good         <= item_chk && item_good;
            res.still_linear       <= linear_next;
            res.good_run_seen      <= (good_dec_next == DEC_TRUE);
            res.bad_run_seen       <= (bad_dec_next == DEC_TRUE);
            res.direction_majority <= majority_next;
            res.good_total         <= TOTAL_W'(good_cnt_next);
            res.heading_x          <= HEAD_W'(step_x_next);
            res.heading_y          <= HEAD_W'(step_y_next);
        end
    end

    assign res.valid = res_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_linear_latched: assert property (@(posedge clk) disable iff (!rst_n)
        !linear_reg |=> !linear_reg)
        else $error("linear flag set again after clearing");

    a_good_dec_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (good_dec_reg != DEC_NONE) |=> (good_dec_reg == $past(good_dec_reg)))
        else $error("good run decision changed after being decided");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && res_valid_reg && !res.ready) |=> (state_reg == S_FIN))
        else $error("verdict released while output register blocked");

    a_first_main: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_cnt_reg != '0) |-> (main_cnt_reg != 2'd0))
        else $error("track has accepted points but no main point");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the track linearity filter.
`timescale 1ns / 1ps

module tb_top;
    import tlf_pkg::*;

    localparam int COORD_W      = 12;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int COUNT_MAX    = (1 << 16) - 1;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 150;
    // SETTLE outlasts the longest busy stretch, a checkpoint with a full angle test.
    localparam int SETTLE       = 30;
    localparam int HOLD_OFF     = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [COORD_W-1:0]         center_x;
        logic [COORD_W-1:0]         center_y;
        logic signed [MOTION_W-1:0] motion_x;
        logic signed [MOTION_W-1:0] motion_y;
    } detection_t;

    typedef struct packed {
        logic                     accepted;
        logic                     checkpoint;
        logic                     point_good;
        logic                     still_linear;
        logic                     good_run_seen;
        logic                     bad_run_seen;
        logic                     direction_majority;
        logic [TOTAL_W-1:0]       good_total;
        logic signed [HEAD_W-1:0] heading_x;
        logic signed [HEAD_W-1:0] heading_y;
    } verdict_t;

    // One row of the directed table; typed rows carry a hand-written verdict.
    typedef struct packed {
        detection_t det;
        logic       typed;
        verdict_t   want;
    } directed_row_t;

    localparam int ROWS = 20;

    // Fields per row: {center_x, center_y, motion_x, motion_y}, typed,
    // {acc, chk, good, linear, good_run, bad_run, majority, total, head_x, head_y}.
    // 13'h1000 is the most negative motion component.
    localparam directed_row_t DIRECTED [ROWS] = '{
        // first detection after reset: accepted, a good checkpoint, one main point
        '{'{12'd100, 12'd100, 13'sd4095, 13'h1000}, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd1, 14'sd0, 14'sd0}},
        // plain item, corner position and opposite motion extremes
        '{'{12'd0, 12'd0, 13'h1000, 13'sd4095}, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd1, 14'sd0, 14'sd0}},
        // first checkpoint with a single main point simply adds the second one
        '{'{12'd200, 12'd100, 13'sd0, 13'sd0}, 1'b1,
          '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2, 14'sd0, 14'sd0}},
        '{'{12'd4095, 12'd4095, 13'sd1, 13'sd0}, 1'b0, '0},
        '{'{12'd250, 12'd150, 13'sd0, -13'sd1}, 1'b0, '0},
        // zero step from the last main point: bad, not accepted, no streak change
        '{'{12'd200, 12'd100, 13'sd5, 13'sd0}, 1'b1,
          '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd2, 14'sd0, 14'sd0}},
        '{'{12'd300, 12'd100, 13'sd10, 13'sd0}, 1'b0, '0},
        '{'{12'd310, 12'd100, 13'sd50, 13'sd0}, 1'b0, '0},
        '{'{12'd320, 12'd100, -13'sd50, 13'sd0}, 1'b0, '0},
        '{'{12'd400, 12'd180, 13'sd3, 13'sd3}, 1'b0, '0},
        '{'{12'd4095, 12'd0, 13'sd4095, 13'sd4095}, 1'b0, '0},
        '{'{12'd0, 12'd4095, 13'h1000, 13'h1000}, 1'b0, '0},
        '{'{12'd0, 12'd0, 13'sd0, 13'sd1}, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 13'sd0, 13'sd0}, 1'b0, '0},
        '{'{12'd0, 12'd4095, -13'sd1, -13'sd1}, 1'b0, '0},
        '{'{12'd4095, 12'd0, 13'h1000, 13'sd4095}, 1'b0, '0},
        '{'{12'd2048, 12'd2048, 13'sd4095, 13'h1000}, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 13'sd4095, 13'sd4095}, 1'b0, '0},
        '{'{12'd0, 12'd0, 13'h1000, 13'h1000}, 1'b0, '0},
        '{'{12'd4095, 12'd4095, 13'sd1, 13'sd1}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tlf_det_if #(.COORD_BITS(COORD_W)) det_ch ();
    tlf_res_if                         res_ch ();

    track_linearity_filter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .det     (det_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Verdicts still owed by the block, oldest first.
    verdict_t pending_verdicts [$];
    int       fail_count;
    int       cycle_count;

    // Receiver controls: a one-off long hold-off, and a no-stall mode.
    int rx_hold_left;
    bit rx_steady;
    bit tx_steady;

    // Shadow copy of the block's configuration and track state.
    int       cfg_run_len;
    int       cfg_cos_limit;
    int       accepted_cnt;
    int       good_cnt;
    int       bad_streak;
    int       first_x, first_y, last_x, last_y;
    int       main_cnt, step_cnt;
    int       step_x, step_y;
    bit       linear;
    int       run_streak;
    bit       run_last;
    run_dec_t good_dec, bad_dec;
    int       agree_cnt, check_cnt;

    // Random track walker that shapes well-formed detections.
    int walk_x, walk_y, dir_x, dir_y;

    function automatic int sat_inc(int v);
        return (v < COUNT_MAX) ? v + 1 : v;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void add_main_point(int x, int y);
        if (main_cnt == 0)
        begin
            first_x = x;
            first_y = y;
        end
        last_x = x;
        last_y = y;
        if (main_cnt < 2)
            main_cnt++;
        good_cnt = sat_inc(good_cnt);
    endfunction

    // Advance both run scans with one checkpoint verdict; decisions latch.
    function automatic void log_verdict(bit ok);
        if (run_streak > 0 && ok == run_last)
            run_streak = sat_inc(run_streak);
        else
        begin
            run_streak = 1;
            run_last   = ok;
        end
        if (good_dec == DEC_NONE)
        begin
            if (ok && run_streak >= cfg_run_len)
                good_dec = DEC_TRUE;
            else if (!ok && run_streak == 2)
                good_dec = DEC_FALSE;
        end
        if (bad_dec == DEC_NONE)
        begin
            if (!ok && run_streak >= cfg_run_len)
                bad_dec = DEC_TRUE;
            else if (ok && run_streak == 2)
                bad_dec = DEC_FALSE;
        end
    endfunction

    function automatic verdict_t predict_verdict(detection_t d);
        verdict_t     v;
        int           cx, cy, mx, my, ux, uy, vx, vy, dot, nu, nv;
        bit           acc, chk, good, angle_ok;
        logic [127:0] lhs, rhs;
        cx   = int'(d.center_x);
        cy   = int'(d.center_y);
        mx   = int'(d.motion_x);
        my   = int'(d.motion_y);
        acc  = 1'b1;
        chk  = 1'b0;
        good = 1'b0;
        if (accepted_cnt == 0)
        begin
            // the very first detection always opens the track
            add_main_point(cx, cy);
            chk  = 1'b1;
            good = 1'b1;
            log_verdict(1'b1);
        end
        else
        begin
            if (step_cnt >= 2)
            begin
                check_cnt = sat_inc(check_cnt);
                if (mx * step_x + my * step_y > 0)
                    agree_cnt = sat_inc(agree_cnt);
            end
            if ((accepted_cnt + 1) % 3 == 0)
            begin
                chk = 1'b1;
                if (main_cnt >= 2)
                begin
                    ux = last_x - first_x;
                    uy = last_y - first_y;
                    vx = cx - last_x;
                    vy = cy - last_y;
                    step_x = vx;
                    step_y = vy;
                    if (step_cnt < 2)
                        step_cnt++;
                    // exact squared-cosine compare, Q16 threshold
                    dot      = ux * vx + uy * vy;
                    nu       = ux * ux + uy * uy;
                    nv       = vx * vx + vy * vy;
                    angle_ok = 1'b0;
                    if (dot >= 0)
                    begin
                        lhs      = (128'(dot) * 128'(dot)) << COS_FRAC_W;
                        rhs      = 128'(nu) * 128'(nv) * 128'(cfg_cos_limit);
                        angle_ok = (lhs >= rhs);
                    end
                    if ((vx == 0 && vy == 0) || (ux == 0 && uy == 0))
                        good = 1'b0;
                    else if (!angle_ok)
                    begin
                        good       = 1'b0;
                        bad_streak = sat_inc(bad_streak);
                        if (bad_streak == 2)
                            linear = 1'b0;
                    end
                    else
                    begin
                        good       = 1'b1;
                        bad_streak = 0;
                        add_main_point(cx, cy);
                    end
                end
                else
                begin
                    good = 1'b1;
                    add_main_point(cx, cy);
                end
                acc = good;
                log_verdict(good);
            end
        end
        if (acc)
            accepted_cnt = sat_inc(accepted_cnt);

        v.accepted           = acc;
        v.checkpoint         = chk;
        v.point_good         = chk && good;
        v.still_linear       = linear;
        v.good_run_seen      = (good_dec == DEC_TRUE);
        v.bad_run_seen       = (bad_dec == DEC_TRUE);
        v.direction_majority = (agree_cnt != 0) && (agree_cnt * 2 >= check_cnt);
        v.good_total         = TOTAL_W'(good_cnt);
        v.heading_x          = HEAD_W'(step_x);
        v.heading_y          = HEAD_W'(step_y);
        return v;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Build one detection: mostly steps along the walker's line with motion
    // along it, plus full-range noise and jumps back against the line.
    task automatic make_detection(output detection_t d);
        int pick, k, mx, my;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            dir_x = int'($urandom_range(0, 16)) - 8;
            dir_y = int'($urandom_range(0, 16)) - 8;
            if (dir_x == 0 && dir_y == 0)
                dir_x = 1;
        end
        if (pick < 10)
        begin
            d.center_x = COORD_W'($urandom);
            d.center_y = COORD_W'($urandom);
            d.motion_x = MOTION_W'($urandom);
            d.motion_y = MOTION_W'($urandom);
        end
        else if (pick < 16)
        begin
            k = $urandom_range(4, 80);
            d.center_x = COORD_W'(clamp(walk_x - k * dir_x, 0, COORD_MAX));
            d.center_y = COORD_W'(clamp(walk_y - k * dir_y, 0, COORD_MAX));
            d.motion_x = MOTION_W'(clamp(-k * dir_x, -4096, 4095));
            d.motion_y = MOTION_W'(clamp(-k * dir_y, -4096, 4095));
        end
        else
        begin
            walk_x += dir_x + int'($urandom_range(0, 2)) - 1;
            walk_y += dir_y + int'($urandom_range(0, 2)) - 1;
            // bounce off the frame edge; the reversal makes bad checkpoints
            if (walk_x < 0 || walk_x > COORD_MAX)
            begin
                dir_x  = -dir_x;
                walk_x = clamp(walk_x, 0, COORD_MAX);
            end
            if (walk_y < 0 || walk_y > COORD_MAX)
            begin
                dir_y  = -dir_y;
                walk_y = clamp(walk_y, 0, COORD_MAX);
            end
            k  = $urandom_range(1, 400);
            mx = dir_x * k + int'($urandom_range(0, 64)) - 32;
            my = dir_y * k + int'($urandom_range(0, 64)) - 32;
            d.center_x = COORD_W'(walk_x);
            d.center_y = COORD_W'(walk_y);
            d.motion_x = MOTION_W'(clamp(mx, -4096, 4095));
            d.motion_y = MOTION_W'(clamp(my, -4096, 4095));
        end
    endtask

    // Offer one detection, hold it until the transaction completes, record the
    // verdict it owes, then idle. Valid stays high when no idle follows.
    task automatic send_detection(input detection_t d, input bit typed, input verdict_t want);
        verdict_t predicted;
        int       gap;
        det_ch.valid    <= 1'b1;
        det_ch.center_x <= d.center_x;
        det_ch.center_y <= d.center_y;
        det_ch.motion_x <= d.motion_x;
        det_ch.motion_y <= d.motion_y;
        do
            @(posedge clk);
        while (!det_ch.ready);
        predicted = predict_verdict(d);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
        gap = tx_steady ? 0 : idle_cycles();
        if (gap > 0)
        begin
            det_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every owed verdict has come back.
    task automatic drain_verdicts();
        det_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // APB write of one register, read back, and update of the shadow copy.
    task automatic write_register(input logic idx, input int value);
        logic [CFG_DATA_W-1:0] readback;
        logic [CFG_DATA_W-1:0] masked;
        masked = (idx == REG_RUN_LENGTH) ? (CFG_DATA_W'(value) & 32'h0000_00FF)
                                         : (CFG_DATA_W'(value) & 32'h0001_FFFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_RUN_LENGTH)
            cfg_run_len = int'(masked);
        else
            cfg_cos_limit = int'(masked);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        check_field((idx == REG_RUN_LENGTH) ? "run_length" : "cos_sq_limit",
                    int'(masked), int'(readback));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle counter: end the run if the block stops making progress.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: compare each verdict transaction with the oldest expectation,
    // then drive ready for the next cycle with random stalls.
    initial
    begin
        verdict_t want;
        verdict_t got;
        int       stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.accepted           = res_ch.accepted;
                got.checkpoint         = res_ch.checkpoint;
                got.point_good         = res_ch.point_good;
                got.still_linear       = res_ch.still_linear;
                got.good_run_seen      = res_ch.good_run_seen;
                got.bad_run_seen       = res_ch.bad_run_seen;
                got.direction_majority = res_ch.direction_majority;
                got.good_total         = res_ch.good_total;
                got.heading_x          = res_ch.heading_x;
                got.heading_y          = res_ch.heading_y;
                if (pending_verdicts.size() == 0)
                begin
                    $error("verdict transaction with no detection outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("checkpoint", want.checkpoint, got.checkpoint);
                    check_field("point_good", want.point_good, got.point_good);
                    check_field("still_linear", want.still_linear, got.still_linear);
                    check_field("good_run_seen", want.good_run_seen, got.good_run_seen);
                    check_field("bad_run_seen", want.bad_run_seen, got.bad_run_seen);
                    check_field("direction_majority", want.direction_majority,
                                got.direction_majority);
                    check_field("good_total", want.good_total, got.good_total);
                    check_field("heading_x", want.heading_x, got.heading_x);
                    check_field("heading_y", want.heading_y, got.heading_y);
                end
            end
            if (rx_hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                stall_left = rx_steady ? 0 : idle_cycles();
            end
        end
    end

    initial
    begin
        detection_t d;
        int         run_len, cos_limit;
        fail_count      = 0;
        rx_hold_left    = 0;
        rx_steady       = 1'b0;
        tx_steady       = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        det_ch.valid    = 1'b0;
        det_ch.center_x = '0;
        det_ch.center_y = '0;
        det_ch.motion_x = '0;
        det_ch.motion_y = '0;

        // shadow state at reset
        cfg_run_len   = int'(RUN_LENGTH_RST);
        cfg_cos_limit = int'(COS_SQ_RST);
        accepted_cnt  = 0;
        good_cnt      = 0;
        bad_streak    = 0;
        first_x       = 0;
        first_y       = 0;
        last_x        = 0;
        last_y        = 0;
        main_cnt      = 0;
        step_cnt      = 0;
        step_x        = 0;
        step_y        = 0;
        linear        = 1'b1;
        run_streak    = 0;
        run_last      = 1'b0;
        good_dec      = DEC_NONE;
        bad_dec       = DEC_NONE;
        agree_cnt     = 0;
        check_cnt     = 0;
        walk_x        = 320;
        walk_y        = 110;
        dir_x         = 5;
        dir_y         = 1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the reset configuration.
        foreach (DIRECTED[i])
            send_detection(DIRECTED[i].det, DIRECTED[i].typed, DIRECTED[i].want);

        // Random phases, each under its own register setting; the extremes and
        // the out-of-range values come first, the last phase is fully random.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_verdicts();
            repeat (SETTLE) @(posedge clk);
            case (ph)
                0: begin run_len = 1;   cos_limit = 0;      end
                1: begin run_len = 255; cos_limit = 65536;  end
                2: begin run_len = 0;   cos_limit = 131071; end
                3: begin run_len = 2;   cos_limit = 60000;  end
                4: begin run_len = 3;   cos_limit = 38457;  end
                default:
                begin
                    run_len   = $urandom_range(0, 255);
                    cos_limit = $urandom_range(0, 131071);
                end
            endcase
            write_register(REG_RUN_LENGTH, run_len);
            write_register(REG_COS_SQ_LIMIT, cos_limit);
            // one phase runs back to back with no idling on either side
            rx_steady = (ph == 4);
            tx_steady = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off the receiver while detections keep coming, so the
                // block backs up and stalls its input
                if (ph == 1 && n == 40)
                    rx_hold_left = HOLD_OFF;
                // pause the sender until the block has handed back everything
                if (ph == 3 && n == 75)
                    drain_verdicts();
                make_detection(d);
                send_detection(d, 1'b0, '0);
            end
        end

        drain_verdicts();
        repeat (SETTLE) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d verdicts never arrived", pending_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
